FILE: rtl/prwd_pkg.sv
`default_nettype none

package prwd_pkg;

    localparam int WORD_W  = 32;
    localparam int CHAN_W  = 6;
    localparam int CHIP_W  = 2;
    localparam int COL_W   = 6;
    localparam int ROW_W   = 7;
    localparam int PH_W    = 8;
    localparam int CODE_W  = 3;
    localparam int INFO_W  = 8;
    localparam int SLOTS   = 5;
    localparam int SLOT_W  = 3;
    localparam int OUT_W   = CHAN_W + CHIP_W + COL_W + ROW_W + PH_W + CODE_W + INFO_W;

    localparam logic [CODE_W-1:0] ERR_UNKNOWN   = 3'd0;
    localparam logic [CODE_W-1:0] ERR_NEAR_FULL = 3'd1;
    localparam logic [CODE_W-1:0] ERR_TIMEOUT   = 3'd2;
    localparam logic [CODE_W-1:0] ERR_TRAILER   = 3'd3;
    localparam logic [CODE_W-1:0] ERR_TOKEN_MGR = 3'd4;
    localparam logic [CODE_W-1:0] ERR_DESYNC    = 3'd5;

    localparam logic [4:0] CHIP_GAP       = 5'd26;
    localparam logic [4:0] CHIP_DUMMY     = 5'd27;
    localparam logic [4:0] CHIP_NEAR_FULL = 5'd28;
    localparam logic [4:0] CHIP_TIMEOUT   = 5'd29;
    localparam logic [4:0] CHIP_TRAILER   = 5'd30;
    localparam logic [4:0] CHIP_DESYNC    = 5'd31;
    localparam logic [4:0] CHIP_HIT_MAX   = 5'd25;

    localparam logic [7:0] TIMEOUT_TAG = 8'h3a;
    localparam logic [ROW_W-1:0] ROW_CENTER = 7'd80;

    typedef enum logic [1:0] {
        CLS_HIT     = 2'd0,
        CLS_ERROR   = 2'd1,
        CLS_TIMEOUT = 2'd2,
        CLS_TRAILER = 2'd3
    } word_class_t;

    // Fields the emitter needs to form the records of one word (the record mask is passed beside it)
    typedef struct packed {
        word_class_t       cls;
        logic [CHAN_W-1:0] chan;
        logic [CHIP_W-1:0] chip;
        logic [COL_W-1:0]  column;
        logic [ROW_W-1:0]  row;
        logic [PH_W-1:0]   pulse_height;
        logic [CODE_W-1:0] error_code;
        logic [INFO_W-1:0] error_info;
        logic [INFO_W-1:0] error_info_alt;
    } decoded_t;

    typedef struct packed {
        logic [INFO_W-1:0] error_info;
        logic [CODE_W-1:0] error_code;
        logic [PH_W-1:0]   pulse_height;
        logic [ROW_W-1:0]  row;
        logic [COL_W-1:0]  column;
        logic [CHIP_W-1:0] chip;
        logic [CHAN_W-1:0] channel;
    } record_t;

    function automatic logic [CHAN_W-1:0] group_offset(input logic [2:0] grp);
        logic [CHAN_W-1:0] ofs;
        case (grp)
            3'd0:    ofs = 6'd0;
            3'd1:    ofs = 6'd4;
            3'd2:    ofs = 6'd9;
            3'd3:    ofs = 6'd13;
            3'd4:    ofs = 6'd18;
            3'd5:    ofs = 6'd22;
            3'd6:    ofs = 6'd27;
            3'd7:    ofs = 6'd31;
            default: ofs = 6'd0;
        endcase
        return ofs;
    endfunction

endpackage

`default_nettype wire

FILE: rtl/pixel_readout_word_decoder_top.sv
// Channel | Dir | Signals                              | Contents
// s_*     | in  | s_tvalid s_tready s_tdata[31:0]      | readout word
// m_*     | out | m_tvalid m_tready m_tdata[39:0]      | hit or error record
//         |     | m_tuser m_tlast                      | kind, last of word
// A word is decoded into a hold register; one record per cycle moves to the
// output register while the output is not stalled. A word with several
// records (up to five for timeout, two for trailer) holds off the input
// until its last record moves to the output register.
// Reset clears the pending mask and output valid; the output register keeps
// its request while m_tready is low, and the input stalls behind it once a word is pending.
`default_nettype none

module pixel_readout_word_decoder_top
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [31:0] s_tdata,   // readout_word
    output logic             m_tvalid,
    input  wire logic        m_tready,
    // channel, chip, column, row, pulse_height, error_code, error_info
    output logic [39:0]      m_tdata,
    output logic             m_tuser,   // result_kind
    output logic             m_tlast    // last
);
    import prwd_pkg::*;

    decoded_t         dec;
    logic [SLOTS-1:0] mask;
    logic             take;
    record_t          rec;

    prwd_decode u_decode
    (
        .word (s_tdata),
        .dec  (dec),
        .mask (mask)
    );

    prwd_emit u_emit
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (s_tvalid && take),
        .dec       (dec),
        .mask      (mask),
        .take      (take),
        .out_ready (m_tready),
        .out_valid (m_tvalid),
        .out_rec   (rec),
        .out_kind  (m_tuser),
        .out_last  (m_tlast)
    );

    assign s_tready = take;
    assign m_tdata  = rec;

endmodule

`default_nettype wire

FILE: rtl/prwd_decode.sv
`default_nettype none

module prwd_decode
(
    input  wire logic [prwd_pkg::WORD_W-1:0] word,
    output prwd_pkg::decoded_t               dec,
    output logic [prwd_pkg::SLOTS-1:0]       mask
);
    import prwd_pkg::*;

    logic [5:0]       w_chan;
    logic [4:0]       w_chip;
    logic [4:0]       w_dcol;
    logic [7:0]       w_code;
    logic [ROW_W-1:0] half;

    assign w_chan = word[31:26];
    assign w_chip = word[25:21];
    assign w_dcol = word[20:16];
    assign w_code = word[15:8];
    assign half   = w_code[7:1];

    always_comb
    begin
        dec                = '0;
        dec.cls            = CLS_HIT;
        mask               = '0;
        if (word[27:0] == 28'd0)
        begin
            mask = '0;
        end
        else if (w_chip > CHIP_HIT_MAX)
        begin
            dec.cls  = CLS_ERROR;
            dec.chan = w_chan;
            if (word == 32'hffff_ffff)
            begin
                dec.chan       = '0;
                dec.error_code = ERR_UNKNOWN;
                mask           = 5'b00001;
            end
            else
            begin
                case (w_chip)
                    CHIP_NEAR_FULL:
                    begin
                        dec.chan       = '0;
                        dec.error_code = ERR_NEAR_FULL;
                        dec.error_info = word[7:0];
                        mask           = 5'b00001;
                    end
                    CHIP_TIMEOUT:
                    begin
                        dec.cls        = CLS_TIMEOUT;
                        dec.chan       = group_offset(word[10:8]);
                        dec.error_code = ERR_TIMEOUT;
                        dec.error_info = word[18:11];
                        if (word[27:20] == TIMEOUT_TAG)
                            mask = word[4:0];
                    end
                    CHIP_TRAILER:
                    begin
                        dec.cls            = CLS_TRAILER;
                        dec.error_code     = ERR_TRAILER;
                        dec.error_info     = {4'd0, word[11:8]};
                        dec.error_info_alt = word[7:0];
                        mask               = {3'd0, |word[7:0], |word[11:8]};
                    end
                    CHIP_DESYNC:
                    begin
                        dec.error_code = ERR_DESYNC;
                        dec.error_info = word[7:0];
                        mask           = 5'b00001;
                    end
                    default:
                        mask = '0;   // gap and dummy words
                endcase
            end
        end
        else if ((w_chan inside {[6'd1:6'd36]}) && (w_chip inside {[5'd1:5'd3]}))
        begin
            dec.chan         = w_chan;
            dec.chip         = CHIP_W'(w_chip - 5'd1);
            dec.column       = {w_dcol, w_code[0]};
            // codes 160 and 161 land on the center and give row zero
            dec.row          = (half >= ROW_CENTER) ? (half - ROW_CENTER) : (ROW_CENTER - half);
            dec.pulse_height = word[7:0];
            mask             = 5'b00001;
        end
    end

endmodule

`default_nettype wire

FILE: rtl/prwd_emit.sv
`default_nettype none

module prwd_emit
(
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         load,
    input  wire prwd_pkg::decoded_t           dec,
    input  wire logic [prwd_pkg::SLOTS-1:0]   mask,
    output logic                              take,
    input  wire logic                         out_ready,
    output logic                              out_valid,
    output prwd_pkg::record_t                 out_rec,
    output logic                              out_kind,
    output logic                              out_last
);
    import prwd_pkg::*;

    decoded_t           hold_reg;
    logic [SLOTS-1:0]   pend_reg;
    logic [SLOTS-1:0]   pend_next;
    logic [SLOTS-1:0]   rest;
    logic [SLOT_W-1:0]  idx;
    logic               has_pend;
    logic               out_adv;
    logic               out_valid_reg;
    logic               out_valid_next;
    record_t            rec_reg;
    record_t            rec_next;
    logic               kind_reg;
    logic               last_reg;

    assign has_pend = |pend_reg;
    assign rest     = pend_reg & (pend_reg - 5'd1);
    assign out_adv  = !out_valid_reg || out_ready;
    assign take     = !has_pend || (out_adv && (rest == '0));

    always_comb
    begin
        idx = '0;
        for (int i = SLOTS - 1; i >= 0; i--)
        begin
            if (pend_reg[i])
                idx = SLOT_W'(i);
        end
    end

    always_comb
    begin
        rec_next              = '0;
        rec_next.channel      = hold_reg.chan;
        rec_next.chip         = hold_reg.chip;
        rec_next.column       = hold_reg.column;
        rec_next.row          = hold_reg.row;
        rec_next.pulse_height = hold_reg.pulse_height;
        rec_next.error_code   = hold_reg.error_code;
        rec_next.error_info   = hold_reg.error_info;
        case (hold_reg.cls)
            CLS_TIMEOUT:
                rec_next.channel = hold_reg.chan + CHAN_W'(idx) + 6'd1;
            CLS_TRAILER:
            begin
                if (idx != '0)
                begin
                    rec_next.error_code = ERR_TOKEN_MGR;
                    rec_next.error_info = hold_reg.error_info_alt;
                end
            end
            default:
                rec_next = rec_next;
        endcase
    end

    always_comb
    begin
        pend_next      = pend_reg;
        out_valid_next = out_valid_reg;
        if (out_adv)
            out_valid_next = has_pend;
        if (load)
            pend_next = mask;
        else if (out_adv && has_pend)
            pend_next = rest;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            pend_reg      <= pend_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
            hold_reg <= dec;
        if (out_adv && has_pend)
        begin
            rec_reg  <= rec_next;
            kind_reg <= (hold_reg.cls != CLS_HIT);
            last_reg <= (rest == '0);
        end
    end

    assign out_valid = out_valid_reg;
    assign out_rec   = rec_reg;
    assign out_kind  = kind_reg;
    assign out_last  = last_reg;

endmodule

`default_nettype wire

FILE: verif/pixel_readout_word_decoder_top_test.sv
`timescale 1ns / 1ps

module pixel_readout_word_decoder_top_test;

    import prwd_pkg::*;

    localparam int  RANDOM_WORDS = 282;
    localparam int  IDLE_PCT     = 28;
    localparam int  STALL_LIMIT  = 500;
    localparam int  DRAIN_CYCLES = 8;
    localparam bit  KIND_HIT     = 1'b0;
    localparam bit  KIND_ERROR   = 1'b1;
    localparam int  SPLIT_CODE   = 2 * ROW_CENTER;

    typedef struct {
        logic              kind;
        logic [CHAN_W-1:0] channel;
        logic [CHIP_W-1:0] chip;
        logic [COL_W-1:0]  column;
        logic [ROW_W-1:0]  row;
        logic [PH_W-1:0]   pulse_height;
        logic [CODE_W-1:0] error_code;
        logic [INFO_W-1:0] error_info;
        logic              last;
    } pixel_record_t;

    class decode_scoreboard;
        pixel_record_t pending_records[$];
        int unsigned   words_seen;
        int unsigned   records_seen;
        int unsigned   hits_seen;
        int unsigned   errors_seen;
        int unsigned   mismatches;

        task report(string msg);
            $display("[%0t] mismatch: %s", $time, msg);
            mismatches++;
        endtask

        function automatic logic [ROW_W-1:0] row_from_code(logic [7:0] code);
            int h;
            if (code == SPLIT_CODE || code == SPLIT_CODE + 1)
                return '0;
            // odd and even codes fold to the same half value
            h = code >> 1;
            return (h >= ROW_CENTER) ? ROW_W'(h - ROW_CENTER) : ROW_W'(ROW_CENTER - h);
        endfunction

        function void push_error(logic [CHAN_W-1:0] chan, logic [CODE_W-1:0] code,
                                 logic [INFO_W-1:0] info);
            pixel_record_t r;
            r = '{KIND_ERROR, chan, '0, '0, '0, '0, code, info, 1'b0};
            pending_records.insert(pending_records.size(), r);
        endfunction

        function void note_word(logic [31:0] w);
            int unsigned       grp_base [8] = '{0, 4, 9, 13, 18, 22, 27, 31};
            int                before_cnt;
            logic [5:0]        chan;
            logic [4:0]        chip;
            logic [7:0]        code;
            pixel_record_t     r;
            before_cnt = pending_records.size();
            chan = w[31:26];
            chip = w[25:21];
            code = w[15:8];
            words_seen++;
            if (w[27:0] == '0)
                return;
            if (chip > CHIP_HIT_MAX)
            begin
                if (w == '1)
                    push_error('0, ERR_UNKNOWN, '0);
                else if (chip == CHIP_NEAR_FULL)
                    push_error('0, ERR_NEAR_FULL, w[7:0]);
                else if (chip == CHIP_TIMEOUT)
                begin
                    if (w[27:20] == TIMEOUT_TAG)
                        for (int i = 0; i < 5; i++)
                            if (w[i])
                                push_error(CHAN_W'(grp_base[w[10:8]] + i + 1), ERR_TIMEOUT,
                                           w[18:11]);
                end
                else if (chip == CHIP_TRAILER)
                begin
                    if (w[11:8] != '0)
                        push_error(chan, ERR_TRAILER, {4'b0, w[11:8]});
                    if (w[7:0] != '0)
                        push_error(chan, ERR_TOKEN_MGR, w[7:0]);
                end
                else if (chip == CHIP_DESYNC)
                    push_error(chan, ERR_DESYNC, w[7:0]);
            end
            else if (chan >= 1 && chan <= 36 && chip >= 1 && chip <= 3)
            begin
                r = '{KIND_HIT, chan, CHIP_W'(chip - 1), {w[20:16], code[0]},
                      row_from_code(code), w[7:0], '0, '0, 1'b0};
                pending_records.insert(pending_records.size(), r);
            end
            if (pending_records.size() > before_cnt)
                pending_records[$].last = 1'b1;
        endfunction

        task cmp_field(string name, int got, int want);
            if (got != want)
                report($sformatf("%s got %0d expected %0d", name, got, want));
        endtask

        task check_record(logic [39:0] data, logic kind, logic last);
            record_t       got;
            pixel_record_t want;
            got = record_t'(data);
            records_seen++;
            if (pending_records.size() == 0)
            begin
                report($sformatf("record with nothing pending, tdata %h", data));
                return;
            end
            want = pending_records.pop_front();
            if (want.kind == KIND_HIT)
                hits_seen++;
            else
                errors_seen++;
            cmp_field("kind", kind, want.kind);
            cmp_field("channel", got.channel, want.channel);
            cmp_field("chip", got.chip, want.chip);
            cmp_field("column", got.column, want.column);
            cmp_field("row", got.row, want.row);
            cmp_field("pulse_height", got.pulse_height, want.pulse_height);
            cmp_field("error_code", got.error_code, want.error_code);
            cmp_field("error_info", got.error_info, want.error_info);
            cmp_field("last", last, want.last);
        endtask

        function int pending();
            return pending_records.size();
        endfunction
    endclass

    logic        clk      = 1'b0;
    logic        rst_n    = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [31:0] s_tdata  = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [39:0] m_tdata;
    logic        m_tuser;
    logic        m_tlast;

    bit               steady = 1'b0;
    int unsigned      stall_cycles = 0;
    decode_scoreboard sb;

    pixel_readout_word_decoder_top dut
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        m_tready <= steady || ($urandom_range(99) >= IDLE_PCT);
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (s_tvalid && s_tready)
                sb.note_word(s_tdata);
            if (m_tvalid && m_tready)
                sb.check_record(m_tdata, m_tuser, m_tlast);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                stall_cycles = 0;
            else
                stall_cycles++;
            if (stall_cycles >= STALL_LIMIT)
            begin
                $display("watchdog: no handshake for %0d cycles", STALL_LIMIT);
                $display("TB_ERROR");
                $finish;
            end
        end
    end

    function automatic logic [31:0] make_word(logic [5:0] chan, logic [4:0] chip,
                                              logic [20:0] low);
        return {chan, chip, low};
    endfunction

    function automatic logic [31:0] hit_word(logic [5:0] chan, logic [4:0] chip,
                                             logic [4:0] dcol, logic [7:0] code,
                                             logic [7:0] ph);
        return make_word(chan, chip, {dcol, code, ph});
    endfunction

    function automatic logic [31:0] timeout_word(logic [3:0] upper, logic [2:0] grp,
                                                 logic [7:0] cnt, logic [4:0] mask);
        return {upper, TIMEOUT_TAG, 1'b0, cnt, grp, 3'b0, mask};
    endfunction

    function automatic logic [31:0] random_word();
        logic [31:0] w;
        int unsigned sel;
        sel = $urandom_range(99);
        w = $urandom;
        if (sel < 40)
            w = hit_word(6'($urandom_range(36, 1)), 5'($urandom_range(3, 1)),
                         5'($urandom_range(31)), 8'($urandom_range(255)),
                         8'($urandom_range(255)));
        else if (sel < 55)
        begin
            // keep the free bits random, force the tag
            w[27:20] = TIMEOUT_TAG;
        end
        else if (sel < 65)
        begin
            w[25:21] = CHIP_TRAILER;
            if ($urandom_range(3) == 0)
                w[11:8] = '0;
            if ($urandom_range(3) == 0)
                w[7:0] = '0;
        end
        else if (sel < 70)
            w[25:21] = CHIP_NEAR_FULL;
        else if (sel < 75)
            w[25:21] = CHIP_DESYNC;
        else if (sel < 80)
            w[25:21] = $urandom_range(1) ? CHIP_GAP : CHIP_DUMMY;
        else if (sel < 83)
            w[27:0] = '0;
        return w;
    endfunction

    task automatic send_word(input logic [31:0] w);
        while (!steady && $urandom_range(99) < IDLE_PCT)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= w;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
    endtask

    initial
    begin : stimulus
        logic [31:0] directed_words[$];
        sb = new();
        directed_words = '{
            32'h0000_0000,
            32'hf000_0000,
            32'hffff_ffff,
            hit_word(6'd1, 5'd1, 5'd0, 8'd0, 8'd0),
            hit_word(6'd36, 5'd3, 5'd31, 8'd255, 8'd255),
            hit_word(6'd5, 5'd2, 5'd7, 8'd160, 8'd3),
            hit_word(6'd5, 5'd2, 5'd7, 8'd161, 8'd4),
            hit_word(6'd9, 5'd1, 5'd3, 8'd1, 8'd5),
            hit_word(6'd12, 5'd3, 5'd1, 8'd158, 8'd6),
            hit_word(6'd0, 5'd1, 5'd4, 8'd20, 8'd7),
            hit_word(6'd37, 5'd2, 5'd4, 8'd20, 8'd8),
            hit_word(6'd63, 5'd3, 5'd4, 8'd20, 8'd9),
            hit_word(6'd10, 5'd0, 5'd4, 8'd20, 8'd10),
            hit_word(6'd10, 5'd4, 5'd4, 8'd20, 8'd11),
            make_word(6'd10, CHIP_HIT_MAX, 21'h1fffff),
            make_word(6'd3, CHIP_GAP, 21'h012345),
            make_word(6'd3, CHIP_DUMMY, 21'h1abcde),
            make_word(6'd7, CHIP_NEAR_FULL, 21'h0000ab),
            timeout_word(4'hf, 3'd7, 8'hff, 5'h1f),
            timeout_word(4'h0, 3'd0, 8'h00, 5'h01),
            timeout_word(4'h5, 3'd3, 8'h5a, 5'h00),
            make_word(6'd2, CHIP_TIMEOUT, 21'h00001f),
            make_word(6'd20, CHIP_TRAILER, 21'h000fff),
            make_word(6'd21, CHIP_TRAILER, 21'h000500),
            make_word(6'd22, CHIP_TRAILER, 21'h000033),
            make_word(6'd23, CHIP_TRAILER, 21'h1f0000),
            make_word(6'd63, CHIP_DESYNC, 21'h0000ff),
            make_word(6'd1, CHIP_DESYNC, 21'h000000)
        };
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        foreach (directed_words[i])
            send_word(directed_words[i]);
        for (int n = 0; n < RANDOM_WORDS; n++)
        begin
            // run a block of words with both sides never idling
            steady = (n >= 120 && n < 200);
            send_word(random_word());
        end
        steady = 1'b0;
        s_tvalid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        $display("decoded %0d readout words into %0d records: %0d hits, %0d errors",
                 sb.words_seen, sb.records_seen, sb.hits_seen, sb.errors_seen);
        $display("mismatches found: %0d", sb.mismatches);
        if (sb.mismatches == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

FILE: sim.f
rtl/prwd_pkg.sv
rtl/prwd_decode.sv
rtl/prwd_emit.sv
rtl/pixel_readout_word_decoder_top.sv
verif/pixel_readout_word_decoder_top_test.sv
